// ===== hw/rtl/sha1_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types, constants and codes for the SHA-1 hash engine.
// ----------------------------------------------------------------------------
package sha1_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [4:0] hash_t;

  // command from the sequencer to the compression unit
  typedef struct packed {
    logic  start;
    logic  push;
    word_t word;
  } ctrl_t;

  // status back from the compression unit
  typedef struct packed {
    logic busy;
    logic done;
  } stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_HASH,
    ST_EMIT
  } state_t;

  localparam logic ACT_ABSORB = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  localparam word_t K_R0 = 32'h5A827999;
  localparam word_t K_R1 = 32'h6ED9EBA1;
  localparam word_t K_R2 = 32'h8F1BBCDC;
  localparam word_t K_R3 = 32'hCA62C1D6;

  localparam hash_t H_INIT = '{
    0: 32'h67452301,
    1: 32'hEFCDAB89,
    2: 32'h98BADCFE,
    3: 32'h10325476,
    4: 32'hC3D2E1F0
  };

  localparam logic [6:0] ROUND_R1   = 7'd20;
  localparam logic [6:0] ROUND_R2   = 7'd40;
  localparam logic [6:0] ROUND_R3   = 7'd60;
  localparam logic [6:0] ROUND_LAST = 7'd79;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;   // bit 448 of the block
  localparam logic [5:0] LAST_POS = 6'd63;   // bit 504 starts the last byte
  localparam logic [2:0] LAST_IDX = 3'd4;

endpackage

// ===== hw/rtl/sha1_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_in_if
// Message input channel: one byte or a finish request per transaction.
// ----------------------------------------------------------------------------
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink (input valid, input action, input data_byte, output ready);
endinterface

// ===== hw/rtl/sha1_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_out_if
// Digest output channel: one 32-bit digest word per transaction.
// ----------------------------------------------------------------------------
interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_index,
                input last_word, output ready);
endinterface

// ===== hw/rtl/sha1_compress.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_compress
// Message schedule shift line and one shared round unit, 80 rounds per block.
// ----------------------------------------------------------------------------
module sha1_compress (
  input  logic             clk,
  input  logic             rst,
  input  sha1_pkg::ctrl_t  ctrl,
  input  sha1_pkg::hash_t  hash_in,
  output sha1_pkg::stat_t  stat,
  output sha1_pkg::hash_t  hash_sum
);
  import sha1_pkg::*;

  word_t      win [16];
  hash_t      v;
  logic [6:0] rnd;
  logic       busy;
  logic       done;

  word_t w_mix;
  word_t w_new;
  word_t f;
  word_t k;
  word_t t;

  always_comb begin
    w_mix = win[13] ^ win[8] ^ win[2] ^ win[0];
    w_new = {w_mix[30:0], w_mix[31]};
    priority if (rnd < ROUND_R1) begin
      f = (v[1] & v[2]) | (~v[1] & v[3]);
      k = K_R0;
    end else if (rnd < ROUND_R2) begin
      f = v[1] ^ v[2] ^ v[3];
      k = K_R1;
    end else if (rnd < ROUND_R3) begin
      f = (v[1] & v[2]) | (v[1] & v[3]) | (v[2] & v[3]);
      k = K_R2;
    end else begin
      f = v[1] ^ v[2] ^ v[3];
      k = K_R3;
    end
    t = {v[0][26:0], v[0][31:27]} + f + v[4] + win[0] + k;
  end

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      hash_sum[i] = hash_in[i] + v[i];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd + 7'd1;
        if (rnd == ROUND_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // working variables and schedule window
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      v <= hash_in;
    end else if (busy) begin
      v[4] <= v[3];
      v[3] <= v[2];
      v[2] <= {v[1][1:0], v[1][31:2]};
      v[1] <= v[0];
      v[0] <= t;
    end
    if (busy || ctrl.push) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= busy ? w_new : ctrl.word;
    end
  end

endmodule

// ===== hw/rtl/sha1_hash_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_hash_engine
// SHA-1 digest of a byte stream, one byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   msg channel: action absorb carries one message byte, action finish
//   closes the message. digest channel: five transactions per finish, the
//   digest words in order from most significant, last_word on the fifth.
// Timing:
//   the absorbed byte that fills a 64-byte block also starts the
//   compression, and msg.ready stays low while the round unit runs its
//   80 rounds, one per cycle, and the chaining values are updated.
//   a finish runs the padding through the same byte path, one byte per
//   cycle (9 to 72 bytes), with one or two compressions, then presents
//   the digest words one per cycle while digest.ready is high.
// Reset:
//   rst clears the sequencer, loads the initial chaining values and
//   zeroes the byte count. A stalled digest word simply holds; no new
//   message byte is taken until the fifth word is delivered.
// ----------------------------------------------------------------------------
module sha1_hash_engine (
  input  logic        clk,
  input  logic        rst,
  sha1_in_if.sink     msg,
  sha1_out_if.source  digest
);
  import sha1_pkg::*;

  state_t      state;
  state_t      state_next;
  hash_t       hash;
  hash_t       hash_sum;
  logic [60:0] byte_count;
  logic [60:0] len_count;
  logic [23:0] acc;
  logic        padding;
  logic        pad_first;
  logic        len_phase;
  logic [2:0]  idx;

  ctrl_t       cmp_ctrl;
  stat_t       cmp_stat;

  logic [5:0]  pos;
  logic        msg_take;
  logic        push;
  logic        is_len;
  logic [7:0]  push_byte;
  logic [63:0] len_shift;

  sha1_compress u_compress (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (cmp_ctrl),
    .hash_in  (hash),
    .stat     (cmp_stat),
    .hash_sum (hash_sum)
  );

  always_comb begin
    pos       = byte_count[5:0];
    msg_take  = msg.valid && msg.ready;
    is_len    = !pad_first && (len_phase || pos == LEN_POS);
    len_shift = {len_count, 3'b000} << {pos[2:0], 3'b000};
    push      = (msg_take && msg.action == ACT_ABSORB) || state == ST_PAD;
    if (state != ST_PAD) begin
      push_byte = msg.data_byte;
    end else if (pad_first) begin
      push_byte = PAD_BYTE;
    end else if (is_len) begin
      push_byte = len_shift[63:56];
    end else begin
      push_byte = 8'h00;
    end
    cmp_ctrl.push  = push && pos[1:0] == 2'b11;
    cmp_ctrl.start = push && pos == LAST_POS;
    cmp_ctrl.word  = {acc, push_byte};
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (msg_take && msg.action == ACT_FINISH) begin
          state_next = ST_PAD;
        end else if (cmp_ctrl.start) begin
          state_next = ST_HASH;
        end
      end
      ST_PAD: begin
        if (cmp_ctrl.start) begin
          state_next = ST_HASH;
        end
      end
      ST_HASH: begin
        if (cmp_stat.done) begin
          if (!padding) begin
            state_next = ST_IDLE;
          end else if (len_phase) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_PAD;
          end
        end
      end
      ST_EMIT: begin
        if (digest.ready && idx == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    msg.ready          = state == ST_IDLE;
    digest.valid       = state == ST_EMIT;
    digest.digest_word = hash[idx];
    digest.word_index  = idx;
    digest.last_word   = idx == LAST_IDX;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      hash       <= H_INIT;
      byte_count <= '0;
      padding    <= 1'b0;
      pad_first  <= 1'b0;
      len_phase  <= 1'b0;
      idx        <= '0;
    end else begin
      state <= state_next;
      if (push) begin
        byte_count <= byte_count + 61'd1;
      end
      if (msg_take && msg.action == ACT_FINISH) begin
        padding   <= 1'b1;
        pad_first <= 1'b1;
      end
      if (state == ST_PAD) begin
        pad_first <= 1'b0;
        if (is_len) begin
          len_phase <= 1'b1;
        end
      end
      if (state == ST_HASH && cmp_stat.done) begin
        hash <= hash_sum;
      end
      if (digest.valid && digest.ready) begin
        if (idx == LAST_IDX) begin
          idx        <= '0;
          hash       <= H_INIT;
          byte_count <= '0;
          padding    <= 1'b0;
          len_phase  <= 1'b0;
        end else begin
          idx <= idx + 3'd1;
        end
      end
    end
  end

  // byte packing and message length
  always_ff @(posedge clk) begin
    if (push) begin
      acc <= {acc[15:0], push_byte};
    end
    if (msg_take && msg.action == ACT_FINISH) begin
      len_count <= byte_count;
    end
  end

`ifndef ASSERT_OFF
  a_ready_idle : assert property (@(posedge clk) disable iff (rst)
    msg.ready |-> !cmp_stat.busy)
    else $error("message taken while compression runs");

  a_done_hash : assert property (@(posedge clk) disable iff (rst)
    cmp_stat.done |-> state == ST_HASH)
    else $error("compression finished outside hash state");

  a_start_pos : assert property (@(posedge clk) disable iff (rst)
    cmp_ctrl.start |=> cmp_stat.busy && byte_count[5:0] == 6'd0)
    else $error("compression started off a block boundary");

  a_last_clear : assert property (@(posedge clk) disable iff (rst)
    (digest.valid && digest.ready && digest.last_word)
      |=> state == ST_IDLE && byte_count == '0 && hash == H_INIT)
    else $error("state not restored after last digest word");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for sha1_hash_engine. Messages of random length
// and content go in one byte per transaction; an in-bench SHA-1 model
// predicts the five digest words of every finish, and the digest channel is
// checked word by word against them, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  import sha1_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 300;
  localparam int LONG_HOLD    = 300;

  typedef struct packed {
    logic       action;
    logic [7:0] data;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic       tx_valid  = 1'b0;
  logic       tx_action = ACT_ABSORB;
  logic [7:0] tx_data   = 8'h00;
  logic       rx_ready  = 1'b0;

  sha1_in_if  msg ();
  sha1_out_if digest ();

  assign msg.valid     = tx_valid;
  assign msg.action    = tx_action;
  assign msg.data_byte = tx_data;
  assign digest.ready  = rx_ready;

  sha1_hash_engine dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg),
    .digest (digest)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  msg_item_t    msg_queue[$];
  digest_beat_t pending_digest_words[$];

  logic [31:0] chain_words [5];
  logic [31:0] block_w [16];
  logic [63:0] msg_bits;

  int  error_count     = 0;
  int  cycle_count     = 0;
  int  items_queued    = 0;
  int  messages_queued = 0;
  int  tx_gap          = 0;
  int  rx_gap          = 0;
  int  hold_cycles     = 0;
  logic in_fire        = 1'b0;
  logic quiet          = 1'b0;
  logic long_hold_req  = 1'b0;
  logic long_hold_used = 1'b0;
  logic tx_valid_next;
  logic rx_ready_next;
  digest_beat_t want;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function void sha_reset();
    chain_words[0] = 32'h67452301;
    chain_words[1] = 32'hEFCDAB89;
    chain_words[2] = 32'h98BADCFE;
    chain_words[3] = 32'h10325476;
    chain_words[4] = 32'hC3D2E1F0;
    msg_bits = 64'd0;
  endfunction

  function void sha_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t;
    int s;
    for (int i = 0; i < 16; i++) w[i] = block_w[i];
    a = chain_words[0];
    b = chain_words[1];
    c = chain_words[2];
    d = chain_words[3];
    e = chain_words[4];
    for (int r = 0; r < 80; r++) begin
      s = r % 16;
      if (r >= 16) begin
        w[s] = rotl32(w[(s + 13) % 16] ^ w[(s + 8) % 16] ^ w[(s + 2) % 16] ^ w[s], 1);
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      t = rotl32(a, 5) + f + e + w[s] + k;
      e = d;
      d = c;
      c = rotl32(b, 30);
      b = a;
      a = t;
    end
    for (int i = 0; i < 16; i++) block_w[i] = w[i];
    chain_words[0] += a;
    chain_words[1] += b;
    chain_words[2] += c;
    chain_words[3] += d;
    chain_words[4] += e;
  endfunction

  function void sha_absorb(input logic [7:0] b);
    logic [5:0] pos;
    logic [3:0] wi;
    int sh;
    pos = msg_bits[8:3];
    wi  = pos[5:2];
    sh  = (3 - int'(pos[1:0])) * 8;
    if (pos[1:0] == 2'd0) begin
      block_w[wi] = {24'h0, b} << sh;
    end else begin
      block_w[wi] |= {24'h0, b} << sh;
    end
    msg_bits += 64'd8;
    if (pos == 6'd63) sha_compress();
  endfunction

  function void sha_finish();
    logic [63:0] len;
    digest_beat_t beat;
    len = msg_bits;
    sha_absorb(8'h80);
    while (msg_bits[8:3] != 6'd56) sha_absorb(8'h00);
    for (int i = 0; i < 8; i++) sha_absorb(len[63 - 8 * i -: 8]);
    for (int i = 0; i < 5; i++) begin
      beat.word = chain_words[i];
      beat.idx  = 3'(i);
      beat.last = (i == 4);
      pending_digest_words.push_back(beat);
    end
    sha_reset();
  endfunction

  task automatic queue_item(input logic action, input logic [7:0] data);
    msg_item_t it;
    it.action = action;
    it.data   = data;
    msg_queue.push_back(it);
    items_queued++;
  endtask

  task automatic queue_message(input int len);
    for (int i = 0; i < len; i++) queue_item(ACT_ABSORB, 8'($urandom));
    queue_item(ACT_FINISH, 8'($urandom));
    messages_queued++;
  endtask

  task automatic queue_random_message();
    int sel;
    int len;
    sel = $urandom_range(0, 9);
    if (sel <= 4) begin
      len = $urandom_range(0, 20);
    end else if (sel == 5) begin
      case ($urandom_range(0, 8))
        0: len = 55;
        1: len = 56;
        2: len = 63;
        3: len = 64;
        4: len = 65;
        5: len = 119;
        6: len = 120;
        7: len = 127;
        default: len = 128;
      endcase
    end else if (sel <= 7) begin
      len = $urandom_range(21, 70);
    end else begin
      len = 0;
    end
    queue_message(len);
  endtask

  // message driver
  always @(negedge clk) begin
    if (in_fire) void'(msg_queue.pop_front());
    if (rst) begin
      tx_valid_next = 1'b0;
    end else if (tx_valid && !in_fire) begin
      tx_valid_next = 1'b1;
    end else begin
      if (!quiet && tx_gap == 0 && $urandom_range(0, 4) == 0) tx_gap = $urandom_range(1, 12);
      if (tx_gap > 0) begin
        tx_gap--;
        tx_valid_next = 1'b0;
      end else if (msg_queue.size() > 0) begin
        tx_valid_next = 1'b1;
        tx_action <= msg_queue[0].action;
        tx_data   <= msg_queue[0].data;
      end else begin
        tx_valid_next = 1'b0;
      end
    end
    tx_valid <= tx_valid_next;
  end

  // digest receiver
  always @(negedge clk) begin
    rx_ready_next = 1'b1;
    if (long_hold_req && !long_hold_used) begin
      hold_cycles    = LONG_HOLD;
      long_hold_used = 1'b1;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      rx_ready_next = 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      rx_ready_next = 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      rx_gap        = $urandom_range(1, 12) - 1;
      rx_ready_next = 1'b0;
    end
    rx_ready <= rx_ready_next;
  end

  // monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= msg.valid && msg.ready;
      if (msg.valid && msg.ready) begin
        if (msg.action == ACT_FINISH) begin
          sha_finish();
        end else begin
          sha_absorb(msg.data_byte);
        end
      end
      if (digest.valid && digest.ready) begin
        if (pending_digest_words.size() == 0) begin
          $error("digest_word unexpected, actual %h", digest.digest_word);
          error_count++;
        end else begin
          want = pending_digest_words.pop_front();
          if (digest.digest_word !== want.word) begin
            $error("digest_word expected %h actual %h", want.word, digest.digest_word);
            error_count++;
          end
          if (digest.word_index !== want.idx) begin
            $error("word_index expected %0d actual %0d", want.idx, digest.word_index);
            error_count++;
          end
          if (digest.last_word !== want.last) begin
            $error("last_word expected %0d actual %0d", want.last, digest.last_word);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sha1_hash_engine regression: fail");
      $finish;
    end
  end

  initial begin
    sha_reset();
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty message, finish byte ignored
    queue_item(ACT_FINISH, 8'hFF);
    messages_queued++;
    // "abc"
    queue_item(ACT_ABSORB, 8'h61);
    queue_item(ACT_ABSORB, 8'h62);
    queue_item(ACT_ABSORB, 8'h63);
    queue_item(ACT_FINISH, 8'h00);
    messages_queued++;
    // byte extremes
    queue_item(ACT_ABSORB, 8'h00);
    queue_item(ACT_ABSORB, 8'hFF);
    queue_item(ACT_ABSORB, 8'h80);
    queue_item(ACT_ABSORB, 8'h7F);
    queue_item(ACT_FINISH, 8'hA5);
    messages_queued++;
    // back-to-back finish
    queue_item(ACT_FINISH, 8'h5A);
    messages_queued++;
    queue_item(ACT_ABSORB, 8'hFF);
    queue_item(ACT_FINISH, 8'hFF);
    messages_queued++;

    while (items_queued < 130) queue_random_message();

    // digest side stalls while messages keep coming
    while (msg_queue.size() != 0) @(negedge clk);
    long_hold_req = 1'b1;
    repeat (4) queue_message($urandom_range(0, 8));

    while (items_queued < 250) queue_random_message();

    // sender waits for every digest word
    while (msg_queue.size() != 0 || pending_digest_words.size() != 0) @(negedge clk);

    while (items_queued < 320) queue_random_message();

    // final stretch without idling
    while (msg_queue.size() != 0) @(negedge clk);
    quiet = 1'b1;
    while (items_queued < 360 || messages_queued < 14) queue_random_message();

    while (msg_queue.size() != 0) @(negedge clk);
    while (pending_digest_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (pending_digest_words.size() != 0) begin
      $error("digest_word missing, %0d still expected", pending_digest_words.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("sha1_hash_engine regression: pass");
    end else begin
      $display("sha1_hash_engine regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sha1_pkg.sv
hw/rtl/sha1_in_if.sv
hw/rtl/sha1_out_if.sv
hw/rtl/sha1_compress.sv
hw/rtl/sha1_hash_engine.sv
tb/tb.sv
